// ----- hdl/sbx_pkg.sv -----
// Shared widths, constants and types of the SBX crossover gene core.
package sbx_pkg;

   localparam int FRAC_BITS = 16;

   // Gene, bound and spread draw width (Q1.F); gate draw width (Q0.F).
   localparam int GENE_W = FRAC_BITS + 1;
   localparam int GATE_W = FRAC_BITS;

   // Internal widths of the spread lane.
   localparam int DIV_W  = FRAC_BITS + 4;      // first divider remainder
   localparam int ROOT_W = FRAC_BITS + 1;      // square root result
   localparam int SQR_W  = FRAC_BITS + 5;      // square root remainder
   localparam int VAL_W  = 2 * FRAC_BITS + 2;  // product u * alpha
   localparam int QUO_W  = 2 * FRAC_BITS + 1;  // second divider quotient
   localparam int DREM_W = FRAC_BITS + 2;      // second divider remainder
   localparam int PROD_W = 3 * FRAC_BITS + 2;  // betaq * d
   localparam int SPR_W  = FRAC_BITS + 4;      // saturated spread
   localparam int SUM_W  = FRAC_BITS + 2;      // y1 + y2
   localparam int CH_W   = FRAC_BITS + 4;      // child before the clamp

   // Pipeline depths.
   localparam int DIV1_N   = FRAC_BITS + 1;
   localparam int SQRT_N   = FRAC_BITS + 1;
   localparam int DIV2_N   = 2 * FRAC_BITS + 1;
   localparam int LANE_LAT = DIV1_N + SQRT_N + DIV2_N + 6;
   localparam int CORE_LAT = LANE_LAT + 2;

   localparam logic [GENE_W-1:0] ONE_Q = GENE_W'(1) << FRAC_BITS;
   localparam logic [GENE_W-1:0] PROB_RESET =
      GENE_W'((64'd9 << FRAC_BITS) / 64'd10);
   localparam logic [SPR_W-1:0] SPREAD_CAP = SPR_W'(1) << (FRAC_BITS + 3);

   // Per-item data that rides alongside the spread lanes.
   typedef struct packed {
      logic              blend;
      logic              swap;
      logic [GENE_W-1:0] gene_a;
      logic [GENE_W-1:0] gene_b;
      logic [GENE_W-1:0] lo;
      logic [GENE_W-1:0] hi;
      logic [SUM_W-1:0]  sum;
   } side_type;

endpackage

// ----- hdl/sbx_spread_lane.sv -----
// Pipelined SBX spread width for one child: divide, square, root, reciprocal, scale.
module sbx_spread_lane (
   input  logic                        clock,
   input  logic [sbx_pkg::GENE_W-1:0]  span,
   input  logic [sbx_pkg::GENE_W-1:0]  gap,
   input  logic [sbx_pkg::GENE_W-1:0]  draw,
   output logic [sbx_pkg::SPR_W-1:0]   spread
);

   // Input stage: divisor d + 2g.
   logic [sbx_pkg::GENE_W-1:0] d0_ff;
   logic [sbx_pkg::GENE_W-1:0] u0_ff;
   logic [sbx_pkg::DIV_W-1:0]  s0_ff;

   always_ff @(posedge clock) begin
      d0_ff <= span;
      u0_ff <= draw;
      s0_ff <= sbx_pkg::DIV_W'(span) + (sbx_pkg::DIV_W'(gap) << 1);
   end

   // Ratio r = d * 2^F / (d + 2g), one quotient bit per stage. Since d <= s the
   // first step needs no shift and the quotient fits F+1 bits.
   logic [sbx_pkg::DIV_W-1:0]  q1rem_ff [sbx_pkg::DIV1_N];
   logic [sbx_pkg::GENE_W-1:0] q1quo_ff [sbx_pkg::DIV1_N];
   logic [sbx_pkg::DIV_W-1:0]  q1div_ff [sbx_pkg::DIV1_N];
   logic [sbx_pkg::GENE_W-1:0] q1d_ff   [sbx_pkg::DIV1_N];
   logic [sbx_pkg::GENE_W-1:0] q1u_ff   [sbx_pkg::DIV1_N];

   for (genvar k = 0; k < sbx_pkg::DIV1_N; k++) begin : g_div1
      logic [sbx_pkg::DIV_W-1:0]  part;
      logic [sbx_pkg::GENE_W-1:0] quo_src;
      logic [sbx_pkg::DIV_W-1:0]  div_src;
      logic [sbx_pkg::GENE_W-1:0] d_src;
      logic [sbx_pkg::GENE_W-1:0] u_src;
      logic                       bit_q;
      if (k == 0) begin : g_first
         assign part    = sbx_pkg::DIV_W'(d0_ff);
         assign quo_src = '0;
         assign div_src = s0_ff;
         assign d_src   = d0_ff;
         assign u_src   = u0_ff;
      end else begin : g_next
         assign part    = q1rem_ff[k-1] << 1;
         assign quo_src = q1quo_ff[k-1];
         assign div_src = q1div_ff[k-1];
         assign d_src   = q1d_ff[k-1];
         assign u_src   = q1u_ff[k-1];
      end
      assign bit_q = (part >= div_src);
      always_ff @(posedge clock) begin
         q1rem_ff[k] <= bit_q ? part - div_src : part;
         q1quo_ff[k] <= {quo_src[sbx_pkg::GENE_W-2:0], bit_q};
         q1div_ff[k] <= div_src;
         q1d_ff[k]   <= d_src;
         q1u_ff[k]   <= u_src;
      end
   end

   // Square of the ratio.
   logic [2*sbx_pkg::GENE_W-1:0] rr_ff;
   logic [sbx_pkg::GENE_W-1:0]   rr_d_ff;
   logic [sbx_pkg::GENE_W-1:0]   rr_u_ff;

   always_ff @(posedge clock) begin
      rr_ff   <= q1quo_ff[sbx_pkg::DIV1_N-1] * q1quo_ff[sbx_pkg::DIV1_N-1];
      rr_d_ff <= q1d_ff[sbx_pkg::DIV1_N-1];
      rr_u_ff <= q1u_ff[sbx_pkg::DIV1_N-1];
   end

   // alpha = 2 - r^2, then p = u * alpha.
   logic [sbx_pkg::GENE_W:0]   alpha;
   logic [sbx_pkg::VAL_W-1:0]  p_in;
   logic [sbx_pkg::VAL_W-1:0]  p_ff;
   logic [sbx_pkg::GENE_W-1:0] p_d_ff;

   assign alpha = ((sbx_pkg::GENE_W + 1)'(1) << (sbx_pkg::FRAC_BITS + 1))
                  - rr_ff[sbx_pkg::FRAC_BITS +: sbx_pkg::GENE_W + 1];
   assign p_in  = sbx_pkg::VAL_W'(rr_u_ff * alpha);

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      p_d_ff <= rr_d_ff;
   end

   // Pick the root operand: p itself, or 2 - p when p is above one.
   logic                       big_in;
   logic [sbx_pkg::VAL_W-1:0]  v_in;
   logic [sbx_pkg::VAL_W-1:0]  v_ff;
   logic                       big_ff;
   logic [sbx_pkg::GENE_W-1:0] v_d_ff;

   assign big_in = p_ff > (sbx_pkg::VAL_W'(1) << (2 * sbx_pkg::FRAC_BITS));
   assign v_in   = big_in ? (sbx_pkg::VAL_W'(1) << (2 * sbx_pkg::FRAC_BITS + 1)) - p_ff
                          : p_ff;

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      big_ff <= big_in;
      v_d_ff <= p_d_ff;
   end

   // Integer square root, one result bit (two operand bits) per stage.
   logic [sbx_pkg::SQR_W-1:0]  sq_rem_ff  [sbx_pkg::SQRT_N];
   logic [sbx_pkg::ROOT_W-1:0] sq_root_ff [sbx_pkg::SQRT_N];
   logic [sbx_pkg::VAL_W-1:0]  sq_v_ff    [sbx_pkg::SQRT_N];
   logic                       sq_big_ff  [sbx_pkg::SQRT_N];
   logic [sbx_pkg::GENE_W-1:0] sq_d_ff    [sbx_pkg::SQRT_N];

   for (genvar k = 0; k < sbx_pkg::SQRT_N; k++) begin : g_sqrt
      logic [sbx_pkg::SQR_W-1:0]  rem_src;
      logic [sbx_pkg::ROOT_W-1:0] root_src;
      logic [sbx_pkg::VAL_W-1:0]  v_src;
      logic                       big_src;
      logic [sbx_pkg::GENE_W-1:0] d_src;
      logic [sbx_pkg::SQR_W-1:0]  cur;
      logic [sbx_pkg::SQR_W-1:0]  trial;
      logic                       ge;
      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign v_src    = v_ff;
         assign big_src  = big_ff;
         assign d_src    = v_d_ff;
      end else begin : g_next
         assign rem_src  = sq_rem_ff[k-1];
         assign root_src = sq_root_ff[k-1];
         assign v_src    = sq_v_ff[k-1];
         assign big_src  = sq_big_ff[k-1];
         assign d_src    = sq_d_ff[k-1];
      end
      assign cur   = (rem_src << 2)
                     | sbx_pkg::SQR_W'(v_src[2*(sbx_pkg::SQRT_N-1-k) +: 2]);
      assign trial = (sbx_pkg::SQR_W'(root_src) << 2) | sbx_pkg::SQR_W'(1);
      assign ge    = (cur >= trial);
      always_ff @(posedge clock) begin
         sq_rem_ff[k]  <= ge ? cur - trial : cur;
         sq_root_ff[k] <= {root_src[sbx_pkg::ROOT_W-2:0], ge};
         sq_v_ff[k]    <= v_src;
         sq_big_ff[k]  <= big_src;
         sq_d_ff[k]    <= d_src;
      end
   end

   // Reciprocal 2^(2F) / root, one quotient bit per stage; a zero root counts as one.
   logic [sbx_pkg::ROOT_W-1:0] root_last;
   logic [sbx_pkg::ROOT_W-1:0] root_div;

   assign root_last = sq_root_ff[sbx_pkg::SQRT_N-1];
   assign root_div  = (root_last == '0) ? sbx_pkg::ROOT_W'(1) : root_last;

   logic [sbx_pkg::DREM_W-1:0] q2rem_ff  [sbx_pkg::DIV2_N];
   logic [sbx_pkg::QUO_W-1:0]  q2quo_ff  [sbx_pkg::DIV2_N];
   logic [sbx_pkg::ROOT_W-1:0] q2div_ff  [sbx_pkg::DIV2_N];
   logic [sbx_pkg::ROOT_W-1:0] q2root_ff [sbx_pkg::DIV2_N];
   logic                       q2big_ff  [sbx_pkg::DIV2_N];
   logic [sbx_pkg::GENE_W-1:0] q2d_ff    [sbx_pkg::DIV2_N];

   for (genvar k = 0; k < sbx_pkg::DIV2_N; k++) begin : g_div2
      logic [sbx_pkg::DREM_W-1:0] rem_src;
      logic [sbx_pkg::QUO_W-1:0]  quo_src;
      logic [sbx_pkg::ROOT_W-1:0] div_src;
      logic [sbx_pkg::ROOT_W-1:0] root_src;
      logic                       big_src;
      logic [sbx_pkg::GENE_W-1:0] d_src;
      logic [sbx_pkg::DREM_W-1:0] cur;
      logic                       ge;
      if (k == 0) begin : g_first
         // The dividend is a single one in its top bit.
         assign rem_src  = '0;
         assign quo_src  = '0;
         assign div_src  = root_div;
         assign root_src = root_last;
         assign big_src  = sq_big_ff[sbx_pkg::SQRT_N-1];
         assign d_src    = sq_d_ff[sbx_pkg::SQRT_N-1];
         assign cur      = (rem_src << 1) | sbx_pkg::DREM_W'(1);
      end else begin : g_next
         assign rem_src  = q2rem_ff[k-1];
         assign quo_src  = q2quo_ff[k-1];
         assign div_src  = q2div_ff[k-1];
         assign root_src = q2root_ff[k-1];
         assign big_src  = q2big_ff[k-1];
         assign d_src    = q2d_ff[k-1];
         assign cur      = rem_src << 1;
      end
      assign ge = (cur >= sbx_pkg::DREM_W'(div_src));
      always_ff @(posedge clock) begin
         q2rem_ff[k]  <= ge ? cur - sbx_pkg::DREM_W'(div_src) : cur;
         q2quo_ff[k]  <= {quo_src[sbx_pkg::QUO_W-2:0], ge};
         q2div_ff[k]  <= div_src;
         q2root_ff[k] <= root_src;
         q2big_ff[k]  <= big_src;
         q2d_ff[k]    <= d_src;
      end
   end

   // Spread = betaq * d / 2^F, saturated.
   logic [sbx_pkg::QUO_W-1:0]  betaq;
   logic [sbx_pkg::PROD_W-1:0] prod_ff;
   logic [sbx_pkg::VAL_W-1:0]  scaled;
   logic [sbx_pkg::SPR_W-1:0]  spread_ff;

   assign betaq = q2big_ff[sbx_pkg::DIV2_N-1] ? q2quo_ff[sbx_pkg::DIV2_N-1]
                : sbx_pkg::QUO_W'(q2root_ff[sbx_pkg::DIV2_N-1]);

   always_ff @(posedge clock) begin
      prod_ff <= betaq * q2d_ff[sbx_pkg::DIV2_N-1];
   end

   assign scaled = prod_ff[sbx_pkg::FRAC_BITS +: sbx_pkg::VAL_W];

   always_ff @(posedge clock) begin
      spread_ff <= (scaled > sbx_pkg::VAL_W'(sbx_pkg::SPREAD_CAP)) ? sbx_pkg::SPREAD_CAP
                 : sbx_pkg::SPR_W'(scaled);
   end

   assign spread = spread_ff;

endmodule

// ----- hdl/sbx_crossover_gene_core.sv -----
// Top level of the bounded SBX crossover gene core (distribution index one).
//
//   channel   ports                              handshake
//   request   start, busy, req_*                 taken when start is high and busy low
//   result    rsp_strobe, rsp_*                  one cycle per item, cannot be held off
//   config    csr_valid, csr_ready, csr_data     written when valid and ready are high
//
// A new item is taken in every cycle; busy is never raised.
// Each result passes the input register, the bit-per-stage divider, square root and
// reciprocal divider chains in each of the two spread lanes, and the result register.
// Reset is synchronous and clears the valid bits of all stages and restores
// the blend probability; items in flight at reset are dropped.
// The receiver has no back-pressure, so the pipeline never stalls.
module sbx_crossover_gene_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [sbx_pkg::GENE_W-1:0]  req_parent_a_gene,
   input  logic [sbx_pkg::GENE_W-1:0]  req_parent_b_gene,
   input  logic [sbx_pkg::GENE_W-1:0]  req_bound_low,
   input  logic [sbx_pkg::GENE_W-1:0]  req_bound_high,
   input  logic                        req_pair_enable,
   input  logic [sbx_pkg::GATE_W-1:0]  req_gate_draw,
   input  logic [sbx_pkg::GENE_W-1:0]  req_spread_draw,
   input  logic                        req_swap_sel,
   output logic                        rsp_strobe,
   output logic [sbx_pkg::GENE_W-1:0]  rsp_child_first,
   output logic [sbx_pkg::GENE_W-1:0]  rsp_child_second,
   output logic                        rsp_blended,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sbx_pkg::GENE_W-1:0]  csr_data
);

   // The pipeline always advances, so requests and register writes are always taken.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Blend probability register.
   logic [sbx_pkg::GENE_W-1:0] prob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prob_ff <= sbx_pkg::PROB_RESET;
      end else if (csr_valid && csr_ready) begin
         prob_ff <= csr_data;
      end
   end

   // Input register stage.
   logic                       in_vld_ff;
   logic [sbx_pkg::GENE_W-1:0] in_a_ff;
   logic [sbx_pkg::GENE_W-1:0] in_b_ff;
   logic [sbx_pkg::GENE_W-1:0] in_lo_ff;
   logic [sbx_pkg::GENE_W-1:0] in_hi_ff;
   logic                       in_en_ff;
   logic [sbx_pkg::GATE_W-1:0] in_gate_ff;
   logic [sbx_pkg::GENE_W-1:0] in_u_ff;
   logic                       in_swap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_a_ff    <= req_parent_a_gene;
      in_b_ff    <= req_parent_b_gene;
      in_lo_ff   <= req_bound_low;
      in_hi_ff   <= req_bound_high;
      in_en_ff   <= req_pair_enable;
      in_gate_ff <= req_gate_draw;
      in_u_ff    <= req_spread_draw;
      in_swap_ff <= req_swap_sel;
   end

   // Order the parents, form the distance and the two bound gaps. A bound that
   // lies inside the parent span gives a zero gap, and a draw above one
   // saturates to one.
   logic [sbx_pkg::GENE_W-1:0] y1, y2, span, gap_lo, gap_hi, u_sat;
   logic                       blend;
   sbx_pkg::side_type          side_in;

   always_comb begin
      y1     = (in_a_ff < in_b_ff) ? in_a_ff : in_b_ff;
      y2     = (in_a_ff < in_b_ff) ? in_b_ff : in_a_ff;
      span   = y2 - y1;
      gap_lo = (y1 > in_lo_ff) ? y1 - in_lo_ff : '0;
      gap_hi = (in_hi_ff > y2) ? in_hi_ff - y2 : '0;
      u_sat  = (in_u_ff > sbx_pkg::ONE_Q) ? sbx_pkg::ONE_Q : in_u_ff;
      blend  = in_en_ff && (sbx_pkg::GENE_W'(in_gate_ff) < prob_ff)
               && (in_a_ff != in_b_ff);
      side_in.blend  = blend;
      side_in.swap   = in_swap_ff;
      side_in.gene_a = in_a_ff;
      side_in.gene_b = in_b_ff;
      side_in.lo     = in_lo_ff;
      side_in.hi     = in_hi_ff;
      side_in.sum    = sbx_pkg::SUM_W'(y1) + sbx_pkg::SUM_W'(y2);
   end

   // Spread lanes for the lower and the upper child.
   logic [sbx_pkg::SPR_W-1:0] spread_lo;
   logic [sbx_pkg::SPR_W-1:0] spread_hi;

   sbx_spread_lane u_lane_lo (
      .clock  (clock),
      .span   (span),
      .gap    (gap_lo),
      .draw   (u_sat),
      .spread (spread_lo)
   );

   sbx_spread_lane u_lane_hi (
      .clock  (clock),
      .span   (span),
      .gap    (gap_hi),
      .draw   (u_sat),
      .spread (spread_hi)
   );

   // Side data and valid bits follow the lanes stage for stage.
   logic              vld_ff  [sbx_pkg::LANE_LAT];
   sbx_pkg::side_type side_ff [sbx_pkg::LANE_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < sbx_pkg::LANE_LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_vld_ff;
         for (int k = 1; k < sbx_pkg::LANE_LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int k = 1; k < sbx_pkg::LANE_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // Raise to the lower bound, then lower to the upper bound, so crossed
   // bounds give the upper bound.
   function automatic logic [sbx_pkg::GENE_W-1:0] clamp_child(
      input logic [sbx_pkg::CH_W-1:0]   c,
      input logic [sbx_pkg::GENE_W-1:0] lo,
      input logic [sbx_pkg::GENE_W-1:0] hi
   );
      logic [sbx_pkg::CH_W-1:0] t;
      t = (c < sbx_pkg::CH_W'(lo)) ? sbx_pkg::CH_W'(lo) : c;
      t = (t > sbx_pkg::CH_W'(hi)) ? sbx_pkg::CH_W'(hi) : t;
      return sbx_pkg::GENE_W'(t);
   endfunction

   // Children: half of sum minus or plus the spread. A lower child below zero
   // is taken as zero.
   sbx_pkg::side_type          side_last;
   logic [sbx_pkg::CH_W-1:0]   sum_x, sp_lo_x, sp_hi_x, c_lo, c_hi;
   logic [sbx_pkg::GENE_W-1:0] child_lo, child_hi;
   logic [sbx_pkg::GENE_W-1:0] first_in, second_in;

   always_comb begin
      side_last = side_ff[sbx_pkg::LANE_LAT-1];
      sum_x     = sbx_pkg::CH_W'(side_last.sum);
      sp_lo_x   = sbx_pkg::CH_W'(spread_lo);
      sp_hi_x   = sbx_pkg::CH_W'(spread_hi);
      c_lo      = (sum_x > sp_lo_x) ? (sum_x - sp_lo_x) >> 1 : '0;
      c_hi      = (sum_x + sp_hi_x) >> 1;
      child_lo  = clamp_child(c_lo, side_last.lo, side_last.hi);
      child_hi  = clamp_child(c_hi, side_last.lo, side_last.hi);
      if (!side_last.blend) begin
         first_in  = side_last.gene_a;
         second_in = side_last.gene_b;
      end else if (side_last.swap) begin
         first_in  = child_hi;
         second_in = child_lo;
      end else begin
         first_in  = child_lo;
         second_in = child_hi;
      end
   end

   // Result register.
   logic                       rsp_strobe_ff;
   logic [sbx_pkg::GENE_W-1:0] rsp_first_ff;
   logic [sbx_pkg::GENE_W-1:0] rsp_second_ff;
   logic                       rsp_blended_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vld_ff[sbx_pkg::LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_first_ff   <= first_in;
      rsp_second_ff  <= second_in;
      rsp_blended_ff <= side_last.blend;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_child_first  = rsp_first_ff;
   assign rsp_child_second = rsp_second_ff;
   assign rsp_blended      = rsp_blended_ff;

endmodule

// ----- hdl/sbx_checker.sv -----
// Port-level checks of the SBX crossover gene core, bound to the top level.
module sbx_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [sbx_pkg::GENE_W-1:0]  req_parent_a_gene,
   input logic [sbx_pkg::GENE_W-1:0]  req_parent_b_gene,
   input logic                        req_pair_enable,
   input logic                        rsp_strobe,
   input logic [sbx_pkg::GENE_W-1:0]  rsp_child_first,
   input logic [sbx_pkg::GENE_W-1:0]  rsp_child_second,
   input logic                        rsp_blended
);

   // No result comes out in the cycle after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // Every result belongs to an item taken a fixed latency earlier.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, sbx_pkg::CORE_LAT))
      else $error("result without a matching item");

   // A blended result needs a pair that was chosen for crossover.
   a_blend_needs_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_blended |-> $past(req_pair_enable, sbx_pkg::CORE_LAT))
      else $error("blend on a pair that was not enabled");

   // A copied result passes both parents through unchanged.
   a_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_blended |->
         rsp_child_first == $past(req_parent_a_gene, sbx_pkg::CORE_LAT) &&
         rsp_child_second == $past(req_parent_b_gene, sbx_pkg::CORE_LAT))
      else $error("copied children differ from parents");

endmodule

bind sbx_crossover_gene_core sbx_checker u_sbx_checker (.*);
